// ===== hw/rtl/mlf_pkg.sv =====
// shared types and constants of the minimum-length line filter
package mlf_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CFG_W  = 7;

	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [BYTE_W-1:0] NUL_BYTE     = 8'h00;

	localparam logic [CFG_W-1:0] MIN_LEN_RESET = 7'd4;

	typedef enum logic {
		ST_RUN,
		ST_EMIT
	} mlf_state_t;

endpackage

// ===== hw/rtl/mlf_ifs.sv =====
// channel interfaces: input bytes, result bytes, threshold writes

interface mlf_in_if;
	import mlf_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              end_of_stream;
	modport source(output valid, output in_byte, output end_of_stream, input ready);
	modport sink(input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface mlf_out_if;
	import mlf_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last_of_run;
	modport source(output valid, output out_byte, output last_of_run, input ready);
	modport sink(input valid, input out_byte, input last_of_run, output ready);
endinterface

interface mlf_cfg_if;
	import mlf_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] min_length;
	modport source(output valid, output min_length, input ready);
	modport sink(input valid, input min_length, output ready);
endinterface

// ===== hw/rtl/min_length_line_filter.sv =====
// minimum-length line filter: top level with segment buffer and burst read-out
//
//  port    | dir | payload                     | request taken when
//  --------+-----+-----------------------------+---------------------------
//  cfg     | in  | min_length                  | cfg.valid && cfg.ready
//  data    | in  | in_byte, end_of_stream      | data.valid && data.ready
//  result  | out | out_byte, last_of_run       | result.valid && result.ready
//
// one input byte per cycle while collecting or passing through, as long as
// the output register drains. reaching the threshold starts a burst of N held
// bytes read from the single-port line store, one per cycle while the output
// drains: input is held off until the burst has been read out. arst_n clears
// control state and sets the threshold to 4; the store needs no clearing. a
// stall on result holds the output register and, through it, the input side.
module min_length_line_filter #(
	parameter int unsigned MAX_LEN = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	mlf_cfg_if.sink   cfg,
	mlf_in_if.sink    data,
	mlf_out_if.source result
);
	import mlf_pkg::*;

	localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int unsigned CW = $clog2(MAX_LEN + 1);

	logic [BYTE_W-1:0] mem [MAX_LEN];

	mlf_state_t state_q, state_d;

	logic [CFG_W-1:0]  min_len_q;
	logic              pass_q;
	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     n_q;
	logic [CW-1:0]     rd_cnt_q;
	logic              rd_valid_s1;
	logic              rd_last_s1;
	logic [BYTE_W-1:0] rd_data_s1;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic [CW-1:0] thr;
	logic [CW-1:0] fill_inc;
	logic          out_free;
	logic          in_acc;
	logic          delim;
	logic          store_en;
	logic          collect_byte;
	logic          burst_go;
	logic          rd_issue;
	logic          mv;
	logic          emit_done;
	logic          direct_vld;
	logic [BYTE_W-1:0] direct_byte;

	// clamp the threshold into 1..MAX_LEN
	always_comb begin
		if (min_len_q == '0) begin
			thr = CW'(1);
		end else if (min_len_q > CFG_W'(MAX_LEN)) begin
			thr = CW'(MAX_LEN);
		end else begin
			thr = CW'(min_len_q);
		end
	end

	assign out_free     = !out_valid_q || result.ready;
	assign in_acc       = data.valid && data.ready;
	assign delim        = (data.in_byte == NEWLINE_BYTE) || (data.in_byte == NUL_BYTE);
	assign store_en     = fill_q < CW'(MAX_LEN);
	assign fill_inc     = store_en ? fill_q + CW'(1) : fill_q;
	assign collect_byte = in_acc && !data.end_of_stream && !pass_q && !delim;
	assign burst_go     = collect_byte && (fill_inc >= thr);

	assign mv        = rd_valid_s1 && out_free;
	assign rd_issue  = (state_q == ST_EMIT) && (rd_cnt_q != n_q) && (!rd_valid_s1 || mv);
	assign emit_done = (state_q == ST_EMIT) && (rd_cnt_q == n_q) && !rd_valid_s1;

	// passthrough answers right away; delimiter and end of stream become a newline
	assign direct_vld  = in_acc && pass_q;
	assign direct_byte = (data.end_of_stream || delim) ? NEWLINE_BYTE : data.in_byte;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (burst_go) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_done) begin
					state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_comb begin
		data.ready = 1'b0;
		case (state_q)
			ST_RUN: begin
				data.ready = out_free;
			end
			ST_EMIT: begin
				data.ready = 1'b0;
			end
			default: begin
				data.ready = 1'b0;
			end
		endcase
	end

	assign cfg.ready          = 1'b1;
	assign result.valid       = out_valid_q;
	assign result.out_byte    = out_byte_q;
	assign result.last_of_run = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			min_len_q   <= MIN_LEN_RESET;
			pass_q      <= 1'b0;
			fill_q      <= '0;
			n_q         <= '0;
			rd_cnt_q    <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				min_len_q <= cfg.min_length;
			end
			if (in_acc) begin
				if (data.end_of_stream || delim) begin
					pass_q <= 1'b0;
					fill_q <= '0;
				end else if (!pass_q) begin
					fill_q <= burst_go ? '0 : fill_inc;
					if (burst_go) begin
						pass_q <= 1'b1;
					end
				end
			end
			if (burst_go) begin
				n_q      <= fill_inc;
				rd_cnt_q <= '0;
			end else if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			if (rd_issue) begin
				rd_valid_s1 <= 1'b1;
			end else if (mv) begin
				rd_valid_s1 <= 1'b0;
			end
			if (mv || direct_vld) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// line store: write while collecting, read during the burst
	always_ff @(posedge clk) begin
		if (collect_byte && store_en) begin
			mem[fill_q[AW-1:0]] <= data.in_byte;
		end
		if (rd_issue) begin
			rd_data_s1 <= mem[rd_cnt_q[AW-1:0]];
			rd_last_s1 <= (rd_cnt_q == n_q - CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (mv) begin
			out_byte_q <= rd_data_s1;
			out_last_q <= rd_last_s1;
		end else if (direct_vld) begin
			out_byte_q <= direct_byte;
			out_last_q <= 1'b1;
		end
	end

endmodule

// ===== hw/rtl/mlf_checker.sv =====
// port-level checks of the minimum-length line filter, bound to the top level
module mlf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_byte,
	input logic       end_of_stream,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last_of_run
);
	import mlf_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(last_of_run))
		else $error("result payload changed while stalled");

	// a delimiter or end of stream yields nothing or a single closing newline
	a_delim_newline: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (end_of_stream || in_byte == NEWLINE_BYTE || in_byte == NUL_BYTE)
		|=> !out_valid || (out_byte == NEWLINE_BYTE && last_of_run))
		else $error("delimiter produced something other than one newline");

	// mid-burst results keep the input side closed
	a_burst_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> !in_ready)
		else $error("input taken during a burst");

endmodule

bind min_length_line_filter mlf_checker u_mlf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (data.valid),
	.in_ready      (data.ready),
	.in_byte       (data.in_byte),
	.end_of_stream (data.end_of_stream),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.out_byte      (result.out_byte),
	.last_of_run   (result.last_of_run)
);

// ===== tb/tb_top.sv =====
// testbench for the minimum-length line filter: directed, backpressure and random segment tests
`timescale 1ns / 100ps

module tb_top;
	import mlf_pkg::*;

	localparam int MAX_LEN    = 64;
	localparam int SETTLE     = 12;
	localparam int END_WAIT   = 80;
	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_of_run;
	} filter_result_t;

	logic clk;
	logic arst_n;

	mlf_cfg_if cfg_if();
	mlf_in_if  in_if();
	mlf_out_if out_if();

	min_length_line_filter #(.MAX_LEN(MAX_LEN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.data(in_if),
		.result(out_if)
	);

	// mirror of the filter state
	logic [BYTE_W-1:0] held_bytes [MAX_LEN];
	int                held_count;
	bit                passing;
	logic [CFG_W-1:0]  min_len_reg;

	filter_result_t pending[$];
	filter_result_t want_r, got_r;

	int  errors;
	int  items_sent;
	int  results_seen;
	int  cfg_writes;
	int  idle_cycles;
	int  burst_left;
	bit  tx_gaps;
	int  rx_mode;
	logic [7:0] rx_pattern;
	int  rx_phase;
	bit  hold_req;
	int  hold_cycles;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int eff_threshold(logic [CFG_W-1:0] v);
		if (v < 1)
			return 1;
		if (v > MAX_LEN)
			return MAX_LEN;
		return int'(v);
	endfunction

	function automatic logic [BYTE_W-1:0] text_byte();
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom_range(1, 255));
		while (b == NEWLINE_BYTE);
		return b;
	endfunction

	// works out the result bytes one input item causes and queues them
	function automatic void filter_predict(logic [BYTE_W-1:0] b, logic eos);
		logic [BYTE_W-1:0] run_bytes[$];
		logic              delim;
		delim = (b == NEWLINE_BYTE) || (b == NUL_BYTE);
		if (eos) begin
			if (passing)
				run_bytes.push_back(NEWLINE_BYTE);
			passing = 1'b0;
			held_count = 0;
		end else if (passing) begin
			if (delim) begin
				run_bytes.push_back(NEWLINE_BYTE);
				passing = 1'b0;
				held_count = 0;
			end else begin
				run_bytes.push_back(b);
			end
		end else if (delim) begin
			held_count = 0;
		end else begin
			if (held_count < MAX_LEN) begin
				held_bytes[held_count] = b;
				held_count++;
			end
			if (held_count >= eff_threshold(min_len_reg)) begin
				for (int i = 0; i < held_count; i++)
					run_bytes.push_back(held_bytes[i]);
				passing = 1'b1;
				held_count = 0;
			end
		end
		for (int i = 0; i < run_bytes.size(); i++)
			pending.push_back('{run_bytes[i], i == run_bytes.size() - 1});
	endfunction

	task automatic note_mismatch(string what, filter_result_t w, filter_result_t g);
		errors++;
		if (errors <= 10)
			$display("mismatch (%s): expected byte %02h last %0b, got byte %02h last %0b",
				what, w.out_byte, w.last_of_run, g.out_byte, g.last_of_run);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready) begin
			got_r = '{out_if.out_byte, out_if.last_of_run};
			results_seen++;
			if (pending.size() == 0) begin
				note_mismatch("no result expected", '0, got_r);
			end else begin
				want_r = pending.pop_front();
				if (got_r.out_byte !== want_r.out_byte)
					note_mismatch("out_byte", want_r, got_r);
				else if (got_r.last_of_run !== want_r.last_of_run)
					note_mismatch("last_of_run", want_r, got_r);
			end
		end
	end

	// watchdog on cycles without any request moving
	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, pending.size());
			$display("status: fail");
			$finish;
		end
	end

	// receiver stall pattern, with a long hold on request
	initial begin
		out_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_if.ready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				case (rx_mode)
					0: out_if.ready <= 1'b1;
					1: out_if.ready <= 1'($urandom_range(0, 1));
					2: out_if.ready <= ($urandom_range(0, 7) != 0);
					default: begin
						out_if.ready <= rx_pattern[rx_phase % 8];
						rx_phase++;
					end
				endcase
			end
		end
	end

	task automatic push_item(logic [BYTE_W-1:0] b, logic eos);
		int gap;
		@(negedge clk);
		if (tx_gaps && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			in_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_if.valid <= 1'b1;
		in_if.in_byte <= b;
		in_if.end_of_stream <= eos;
		do
			@(posedge clk);
		while (!in_if.ready);
		filter_predict(b, eos);
		items_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic drain(int settle);
		@(negedge clk);
		in_if.valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_min_length(logic [CFG_W-1:0] v);
		drain(SETTLE);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.min_length <= v;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		min_len_reg = v;
		cfg_writes++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// threshold 4 out of reset: short lines dropped, long ones passed, end of stream
	task automatic test_default_threshold();
		push_item("a", 1'b0);
		push_item("b", 1'b0);
		push_item("c", 1'b0);
		push_item(NEWLINE_BYTE, 1'b0);
		push_item(8'h01, 1'b0);
		push_item(8'h7F, 1'b0);
		push_item(8'h80, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'h0B, 1'b0);
		push_item(NUL_BYTE, 1'b0);
		push_item(8'h09, 1'b0);
		push_item("x", 1'b0);
		push_item(8'hFF, 1'b1);
		push_item("q", 1'b0);
		push_item("r", 1'b0);
		push_item("s", 1'b0);
		push_item("t", 1'b0);
		push_item(NEWLINE_BYTE, 1'b1);
		push_item(NUL_BYTE, 1'b1);
	endtask

	// zero acts as one: every non-delimiter opens passthrough at once
	task automatic test_min_one_threshold();
		write_min_length(7'd0);
		push_item("z", 1'b0);
		push_item(NEWLINE_BYTE, 1'b0);
		push_item(NEWLINE_BYTE, 1'b0);
		push_item(8'hFE, 1'b0);
		push_item(8'h55, 1'b1);
	endtask

	// threshold dropped below the held count while collecting
	task automatic test_lowered_threshold();
		write_min_length(7'd10);
		repeat (5) push_item(text_byte(), 1'b0);
		write_min_length(7'd3);
		push_item(8'hAA, 1'b0);
		push_item(NUL_BYTE, 1'b0);
	endtask

	// receiver holds off while a full-length burst builds up behind it
	task automatic test_backpressure();
		write_min_length(7'd64);
		tx_gaps = 1'b0;
		rx_mode = 0;
		hold_cycles = 300;
		hold_req = 1'b1;
		repeat (66) push_item(text_byte(), 1'b0);
		push_item(NEWLINE_BYTE, 1'b0);
		repeat (5) push_item(text_byte(), 1'b0);
		push_item(8'h00, 1'b1);
	endtask

	task automatic run_segments(logic [CFG_W-1:0] v, int target);
		int start;
		int thr;
		int len;
		int r;
		write_min_length(v);
		thr = eff_threshold(v);
		tx_gaps = ($urandom_range(0, 3) != 0);
		rx_mode = $urandom_range(0, 3);
		// keep at least one ready slot in the pattern
		rx_pattern = 8'($urandom) | 8'h01;
		start = items_sent;
		while (items_sent - start < target) begin
			if ($urandom_range(0, 9) < 8) begin
				case ($urandom_range(0, 3))
					0: len = thr - 1;
					1: len = thr;
					2: len = thr + $urandom_range(1, 6);
					default: len = $urandom_range(0, thr > 8 ? 8 : thr);
				endcase
				repeat (len) push_item(text_byte(), 1'b0);
				r = $urandom_range(0, 5);
				if (r < 3)
					push_item(NEWLINE_BYTE, 1'b0);
				else if (r < 5)
					push_item(NUL_BYTE, 1'b0);
				else
					push_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
			end else begin
				// noise, delimiters and stray stream ends mixed in
				repeat ($urandom_range(1, 6)) begin
					r = $urandom_range(0, 7);
					push_item(r == 0 ? NEWLINE_BYTE : r == 1 ? NUL_BYTE
						: BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
				end
			end
		end
	endtask

	task automatic test_random_segments();
		run_segments(7'd3, 32);
		run_segments(7'd1, 32);
		run_segments(7'd0, 24);
		run_segments(7'd127, 24);
		run_segments(7'd9, 32);
		run_segments(CFG_W'($urandom_range(2, 20)), 32);
		run_segments(7'd2, 24);
	endtask

	initial begin
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.in_byte = '0;
		in_if.end_of_stream = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.min_length = '0;
		held_count = 0;
		passing = 1'b0;
		min_len_reg = MIN_LEN_RESET;
		tx_gaps = 1'b1;
		rx_mode = 2;
		rx_pattern = 8'b1011_0110;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_threshold();
		test_min_one_threshold();
		test_lowered_threshold();
		test_backpressure();
		test_random_segments();

		drain(END_WAIT);
		$display("covered %0d input items and %0d result bytes over %0d threshold writes",
			items_sent, results_seen, cfg_writes);
		$display("thresholds 0, 1, 64 and 127 used, long receiver hold with a full burst");
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
